FILE: design/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants of the UTF-8 string validator: error kinds,
// byte classes, code point bounds and the per-string decode state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8v_pkg;

  // Error kind reported with each string verdict
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NUL       = 3'd1,
    ERR_LEAD      = 3'd2,
    ERR_CONT      = 3'd3,
    ERR_TRUNC     = 3'd4,
    ERR_OVERLONG  = 3'd5,
    ERR_SURROGATE = 3'd6,
    ERR_ABOVE     = 3'd7
  } u8v_err_e;

  localparam int unsigned CpWidth = 21;

  // Lead byte ranges
  localparam logic [7:0] Lead2Min = 8'hC2;
  localparam logic [7:0] Lead2Max = 8'hDF;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead3Max = 8'hEF;
  localparam logic [7:0] Lead4Min = 8'hF0;
  localparam logic [7:0] Lead4Max = 8'hF4;
  localparam logic [7:0] AsciiMax = 8'h7F;

  // Continuation byte: 10xx_xxxx
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;

  // Code point bounds
  localparam logic [CpWidth-1:0] MinCp3  = 21'h000800;
  localparam logic [CpWidth-1:0] MinCp4  = 21'h010000;
  localparam logic [CpWidth-1:0] SurrMin = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrMax = 21'h00DFFF;
  localparam logic [CpWidth-1:0] CpMax   = 21'h10FFFF;

  // Decode state carried across the bytes of one string
  typedef struct packed {
    logic [1:0]         pending;   // continuation bytes still expected
    logic [1:0]         seq_len;   // continuation count of the open sequence
    logic [CpWidth-1:0] point;     // code point assembled so far
    u8v_err_e           err;       // first error of the string
  } u8v_state_t;

  localparam u8v_state_t StateClear = '{
    pending: 2'd0,
    seq_len: 2'd0,
    point:   '0,
    err:     ERR_NONE
  };

endpackage

FILE: design/u8v_step.sv
// ----------------------------------------------------------------------------
// u8v_step
// Combinational decode of one item: folds a byte (or an end mark) into the
// string state and gives the next state and, at string end, the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8v_step (
  input  u8v_pkg::u8v_state_t cur_i,
  input  logic [7:0]          data_byte_i,
  input  logic                is_last_i,
  input  logic                end_only_i,
  output u8v_pkg::u8v_state_t nxt_o,
  output logic                done_o,
  output u8v_pkg::u8v_err_e   kind_o
);

  u8v_pkg::u8v_state_t tk;        // state after taking the byte
  u8v_pkg::u8v_state_t fin;       // state whose verdict is reported
  logic [u8v_pkg::CpWidth-1:0] shifted;
  u8v_pkg::u8v_err_e           chk;

  // Code point with the continuation payload shifted in
  assign shifted = {cur_i.point[u8v_pkg::CpWidth-7:0], data_byte_i[5:0]};

  // Checks on a completed multi-byte sequence, in priority order
  always_comb begin
    if ((cur_i.seq_len == 2'd2 && shifted < u8v_pkg::MinCp3) ||
        (cur_i.seq_len == 2'd3 && shifted < u8v_pkg::MinCp4)) begin
      chk = u8v_pkg::ERR_OVERLONG;
    end else if (shifted >= u8v_pkg::SurrMin && shifted <= u8v_pkg::SurrMax) begin
      chk = u8v_pkg::ERR_SURROGATE;
    end else if (shifted > u8v_pkg::CpMax) begin
      chk = u8v_pkg::ERR_ABOVE;
    end else begin
      chk = u8v_pkg::ERR_NONE;
    end
  end

  // Byte decode; nothing changes once an error is latched
  always_comb begin
    tk = cur_i;
    if (cur_i.err == u8v_pkg::ERR_NONE) begin
      if (cur_i.pending != 2'd0) begin
        if ((data_byte_i & u8v_pkg::ContMask) != u8v_pkg::ContTag) begin
          tk.err = u8v_pkg::ERR_CONT;
        end else if (cur_i.pending == 2'd1) begin
          tk.pending = 2'd0;
          tk.seq_len = 2'd0;
          tk.point   = '0;
          tk.err     = chk;
        end else begin
          tk.pending = cur_i.pending - 2'd1;
          tk.point   = shifted;
        end
      end else if (data_byte_i == 8'h00) begin
        tk.err = u8v_pkg::ERR_NUL;
      end else if (data_byte_i <= u8v_pkg::AsciiMax) begin
        tk = cur_i;
      end else if (data_byte_i >= u8v_pkg::Lead2Min && data_byte_i <= u8v_pkg::Lead2Max) begin
        tk.pending = 2'd1;
        tk.seq_len = 2'd1;
        tk.point   = {{(u8v_pkg::CpWidth-5){1'b0}}, data_byte_i[4:0]};
      end else if (data_byte_i >= u8v_pkg::Lead3Min && data_byte_i <= u8v_pkg::Lead3Max) begin
        tk.pending = 2'd2;
        tk.seq_len = 2'd2;
        tk.point   = {{(u8v_pkg::CpWidth-4){1'b0}}, data_byte_i[3:0]};
      end else if (data_byte_i >= u8v_pkg::Lead4Min && data_byte_i <= u8v_pkg::Lead4Max) begin
        tk.pending = 2'd3;
        tk.seq_len = 2'd3;
        tk.point   = {{(u8v_pkg::CpWidth-3){1'b0}}, data_byte_i[2:0]};
      end else begin
        tk.err = u8v_pkg::ERR_LEAD;
      end
    end
  end

  // String end: end_only skips the byte entirely
  assign fin    = end_only_i ? cur_i : tk;
  assign done_o = end_only_i | is_last_i;
  assign nxt_o  = done_o ? u8v_pkg::StateClear : tk;

  // Verdict: latched error first, then an unfinished sequence
  always_comb begin
    if (fin.err != u8v_pkg::ERR_NONE) begin
      kind_o = fin.err;
    end else if (fin.pending != 2'd0) begin
      kind_o = u8v_pkg::ERR_TRUNC;
    end else begin
      kind_o = u8v_pkg::ERR_NONE;
    end
  end

endmodule

FILE: design/utf8_string_validator.sv
// ----------------------------------------------------------------------------
// utf8_string_validator
// Strict UTF-8 checker for byte strings, one byte per item, one verdict per
// string end.
// ----------------------------------------------------------------------------
// Takes one item per cycle while no verdict waits under out_stall_i. An item
// is registered on entry, then decoded combinationally against the string
// state, and a string verdict lands in the output register; out_valid_o rises
// once the item that ends the string is decoded. The registered state update
// in the decode stage sets the rate. A verdict waiting under out_stall_i holds
// only items that end a string; bytes inside a string keep flowing. string_ok_o
// is 1 for a valid string, and error_kind_o names the first problem found (NUL,
// bad lead, bad continuation, truncated, overlong, surrogate, above 10FFFF).
`timescale 1ns / 1ps

module utf8_string_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  input  logic       end_only_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       string_ok_o,
  output logic [2:0] error_kind_o
);

  logic                valid_q;
  logic [7:0]          byte_q;
  logic                last_q;
  logic                endo_q;
  u8v_pkg::u8v_state_t st_q;
  u8v_pkg::u8v_state_t st_d;
  logic                done;
  u8v_pkg::u8v_err_e   kind;
  logic                out_valid_q;
  logic                ok_q;
  u8v_pkg::u8v_err_e   kind_q;
  logic                out_free;
  logic                adv;
  logic                in_acc;

  // Stage advance: items that end a string need a free output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = valid_q && (!done || out_free);
  assign in_stall_o = valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_acc) begin
      valid_q <= 1'b1;
    end else if (adv) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= data_byte_i;
      last_q <= is_last_i;
      endo_q <= end_only_i;
    end
  end

  // Decode of the registered item
  u8v_step u_step (
    .cur_i       (st_q),
    .data_byte_i (byte_q),
    .is_last_i   (last_q),
    .end_only_i  (endo_q),
    .nxt_o       (st_d),
    .done_o      (done),
    .kind_o      (kind)
  );

  // String state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= u8v_pkg::StateClear;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && done) begin
      ok_q   <= (kind == u8v_pkg::ERR_NONE);
      kind_q <= kind;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign string_ok_o  = ok_q;
  assign error_kind_o = kind_q;

endmodule

FILE: verif/utf8_verdict_checker.sv
// ----------------------------------------------------------------------------
// utf8_verdict_checker
// Watches both channels of the UTF-8 string validator. Every accepted input
// item runs through a local decoder; each string end queues the expected
// verdict, and every accepted output item is compared with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_verdict_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  input  logic       end_only_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       string_ok_i,
  input  logic [2:0] error_kind_i,
  output int         fail_count_o,
  output int         pending_count_o,
  output int         verdict_count_o,
  output int         valid_count_o
);

  typedef struct packed {
    logic              ok;
    u8v_pkg::u8v_err_e kind;
  } verdict_t;

  u8v_pkg::u8v_state_t dec;
  verdict_t            expected_verdicts[$];
  int                  fail_count;
  int                  verdict_count;
  int                  valid_count;

  assign fail_count_o    = fail_count;
  assign pending_count_o = expected_verdicts.size();
  assign verdict_count_o = verdict_count;
  assign valid_count_o   = valid_count;

  // Decode one item against the string state; returns 1 at a string end
  function automatic bit predict_verdict(input logic [7:0] b, input logic last,
                                         input logic eo, output verdict_t v);
    u8v_pkg::u8v_err_e kind;
    v = '{ok: 1'b0, kind: u8v_pkg::ERR_NONE};
    // bytes after the first error are not decoded
    if (!eo && dec.err == u8v_pkg::ERR_NONE) begin
      if (dec.pending != 2'd0) begin
        if ((b & u8v_pkg::ContMask) != u8v_pkg::ContTag) begin
          dec.err = u8v_pkg::ERR_CONT;
        end else begin
          dec.point   = {dec.point[u8v_pkg::CpWidth-7:0], b[5:0]};
          dec.pending = dec.pending - 2'd1;
          // sequence complete: overlong, then surrogate, then range
          if (dec.pending == 2'd0) begin
            if ((dec.seq_len == 2'd2 && dec.point < u8v_pkg::MinCp3) ||
                (dec.seq_len == 2'd3 && dec.point < u8v_pkg::MinCp4)) begin
              dec.err = u8v_pkg::ERR_OVERLONG;
            end else if (dec.point >= u8v_pkg::SurrMin &&
                         dec.point <= u8v_pkg::SurrMax) begin
              dec.err = u8v_pkg::ERR_SURROGATE;
            end else if (dec.point > u8v_pkg::CpMax) begin
              dec.err = u8v_pkg::ERR_ABOVE;
            end
            dec.seq_len = 2'd0;
            dec.point   = '0;
          end
        end
      end else if (b == 8'h00) begin
        dec.err = u8v_pkg::ERR_NUL;
      end else if (b <= u8v_pkg::AsciiMax) begin
        // plain ASCII, nothing to keep
      end else if (b >= u8v_pkg::Lead2Min && b <= u8v_pkg::Lead2Max) begin
        dec.pending    = 2'd1;
        dec.seq_len    = 2'd1;
        dec.point      = '0;
        dec.point[4:0] = b[4:0];
      end else if (b >= u8v_pkg::Lead3Min && b <= u8v_pkg::Lead3Max) begin
        dec.pending    = 2'd2;
        dec.seq_len    = 2'd2;
        dec.point      = '0;
        dec.point[3:0] = b[3:0];
      end else if (b >= u8v_pkg::Lead4Min && b <= u8v_pkg::Lead4Max) begin
        dec.pending    = 2'd3;
        dec.seq_len    = 2'd3;
        dec.point      = '0;
        dec.point[2:0] = b[2:0];
      end else begin
        dec.err = u8v_pkg::ERR_LEAD;
      end
    end
    if (!eo && !last) return 1'b0;
    // string end: an open sequence without earlier error is a cut-off
    kind = dec.err;
    if (kind == u8v_pkg::ERR_NONE && dec.pending != 2'd0) kind = u8v_pkg::ERR_TRUNC;
    v.ok   = (kind == u8v_pkg::ERR_NONE);
    v.kind = kind;
    dec    = u8v_pkg::StateClear;
    return 1'b1;
  endfunction

  // Sample both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    verdict_t got;
    if (!rst_ni) begin
      dec = u8v_pkg::StateClear;
      expected_verdicts.delete();
      fail_count    = 0;
      verdict_count = 0;
      valid_count   = 0;
    end else begin
      // output side: compare with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict ok=%0b kind=%0d, none expected",
                   $time, string_ok_i, error_kind_i);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          verdict_count++;
          if (want.ok) valid_count++;
          if (string_ok_i !== want.ok) begin
            $display("%0t: string_ok mismatch: expected %0b, actual %0b",
                     $time, want.ok, string_ok_i);
            fail_count++;
          end
          if (error_kind_i !== want.kind) begin
            $display("%0t: error_kind mismatch: expected %0d (%s), actual %0d",
                     $time, want.kind, want.kind.name(), error_kind_i);
            fail_count++;
          end
        end
      end
      // input side: predict
      if (in_valid_i && !in_stall_i) begin
        if (predict_verdict(data_byte_i, is_last_i, end_only_i, got)) begin
          expected_verdicts.insert(expected_verdicts.size(), got);
        end
      end
    end
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the UTF-8 string validator. A directed set hits
// the byte class edges and every error kind, then random strings follow:
// mostly well-formed text, some with one injected fault, some raw noise.
// Both channels idle in short random bursts, except near the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int NumItems  = 1950;
  localparam int CalmItems = 200;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       is_last_i   = 1'b0;
  logic       end_only_i  = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       string_ok_o;
  logic [2:0] error_kind_o;

  int fail_count;
  int pending_count;
  int verdict_count;
  int valid_count;

  int         items_sent   = 0;
  int         strings_sent = 0;
  bit         idle_on      = 1'b1;
  int         stall_left   = 0;
  logic [7:0] byte_q[$];

  utf8_string_validator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .end_only_i  (end_only_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .string_ok_o (string_ok_o),
    .error_kind_o(error_kind_o)
  );

  utf8_verdict_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .is_last_i      (is_last_i),
    .end_only_i     (end_only_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .string_ok_i    (string_ok_o),
    .error_kind_i   (error_kind_o),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .verdict_count_o(verdict_count),
    .valid_count_o  (valid_count)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stalls in random bursts while idle_on is set
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Drive one item and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic last, input logic eo);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    is_last_i   <= last;
    end_only_i  <= eo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Send the queued bytes as one string, closed by is_last or end_only
  task automatic send_string(input bit close_eo);
    bit eo;
    eo = close_eo || byte_q.size() == 0;
    for (int i = 0; i < byte_q.size(); i++) begin
      send_item(byte_q[i], !eo && i == byte_q.size() - 1, 1'b0);
    end
    if (eo) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    byte_q.delete();
    strings_sent++;
  endtask

  // Append one byte to the string being built
  task automatic add_byte(input logic [7:0] b);
    byte_q.insert(byte_q.size(), b);
  endtask

  // Encode a code point in n bytes, whether or not that form is legal
  task automatic push_point(input logic [20:0] cp, input int n);
    case (n)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Random legal code point in its shortest form; n = 1 for ASCII
  task automatic push_valid_point(input int n);
    logic [20:0] cp;
    case (n)
      1: cp = 21'($urandom_range(1, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= u8v_pkg::SurrMin) cp = cp + 21'h800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    push_point(cp, n);
  endtask

  // Append one fault of the given kind; returns 1 if the string must end now
  task automatic push_fault(input u8v_pkg::u8v_err_e kind, output bit must_close);
    logic [7:0] b;
    int         n;
    must_close = 1'b0;
    n = $urandom_range(2, 4);
    case (kind)
      u8v_pkg::ERR_NUL: add_byte(8'h00);
      u8v_pkg::ERR_LEAD: begin
        do b = 8'($urandom_range(0, 255));
        while (!((b >= 8'h80 && b <= 8'hC1) || b >= 8'hF5));
        add_byte(b);
      end
      u8v_pkg::ERR_CONT: begin
        push_valid_point(n);
        repeat ($urandom_range(1, n - 1)) void'(byte_q.pop_back());
        do b = 8'($urandom_range(0, 255));
        while (b[7:6] == 2'b10);
        add_byte(b);
      end
      u8v_pkg::ERR_TRUNC: begin
        push_valid_point(n);
        repeat ($urandom_range(1, n - 1)) void'(byte_q.pop_back());
        must_close = 1'b1;
      end
      u8v_pkg::ERR_OVERLONG: begin
        if ($urandom_range(0, 1)) push_point(21'($urandom_range(0, 'h7FF)), 3);
        else push_point(21'($urandom_range(0, 'hFFFF)), 4);
      end
      u8v_pkg::ERR_SURROGATE: push_point(21'($urandom_range('hD800, 'hDFFF)), 3);
      default: push_point(21'($urandom_range('h110000, 'h13FFFF)), 4);
    endcase
  endtask

  // Main stimulus
  initial begin
    int                mode;
    bit                must_close;
    u8v_pkg::u8v_err_e fault;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte class edges, every error kind, end-mark corner cases
    send_string(1'b1);                                            // empty string
    add_byte(8'h7F); send_string(1'b0);
    add_byte(8'h00); add_byte(8'hC2); send_string(1'b0);
    add_byte(8'h80); send_string(1'b0);
    add_byte(8'hC1); send_string(1'b0);
    push_point(21'h7FF, 2); send_string(1'b0);                    // DF BF
    push_point(21'h7FF, 3); send_string(1'b0);                    // overlong
    push_point(u8v_pkg::SurrMin, 3); send_string(1'b0);           // surrogate
    push_point(21'h110000, 4); send_string(1'b0);                 // above max
    push_point(u8v_pkg::CpMax, 4); send_string(1'b0);             // largest legal
    add_byte(8'hC2); add_byte(8'h41); send_string(1'b0);
    add_byte(8'hC2); send_string(1'b1);                           // cut off
    send_item(8'h41, 1'b1, 1'b1);                                 // both end marks
    strings_sent++;

    // random strings
    while (items_sent < NumItems) begin
      idle_on = items_sent < NumItems - CalmItems;
      mode = $urandom_range(0, 19);
      must_close = 1'b0;
      if (mode < 11) begin
        // well-formed text
        repeat ($urandom_range(0, 6)) push_valid_point($urandom_range(1, 4));
      end else if (mode < 17) begin
        // legal text around one fault
        repeat ($urandom_range(0, 3)) push_valid_point($urandom_range(1, 4));
        fault = u8v_pkg::u8v_err_e'($urandom_range(1, 7));
        push_fault(fault, must_close);
        if (!must_close) begin
          repeat ($urandom_range(0, 3)) push_valid_point($urandom_range(1, 4));
        end
      end else begin
        // raw noise
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
      send_string(must_close || $urandom_range(0, 5) == 0);
    end
    in_valid_i <= 1'b0;

    // drain, then allow the pipeline latency to pass
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d items in %0d strings; %0d verdicts checked, %0d valid.",
             items_sent, strings_sent, verdict_count, valid_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("tb failed");
    $finish;
  end

endmodule
